[rtl/smpp_pkg.sv]
// Shared types and constants of the serial memory programmer protocol unit.
`default_nettype none

package smpp_pkg;

    // Width of the reply byte counter; a chunk never exceeds 63 bytes.
    localparam int CNT_W = 6;

    // Protocol phases
    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_CMD       = 3'd1;
    localparam logic [2:0] PH_ACK_LEN   = 3'd2;
    localparam logic [2:0] PH_ACK_BODY  = 3'd3;
    localparam logic [2:0] PH_LOAD_LEN  = 3'd4;
    localparam logic [2:0] PH_LOAD_BODY = 3'd5;

    // Error codes
    localparam logic [1:0] ERR_RESET      = 2'd0;
    localparam logic [1:0] ERR_CORRUPT    = 2'd1;
    localparam logic [1:0] ERR_UNEXPECTED = 2'd2;
    localparam logic [1:0] ERR_UNKNOWN    = 2'd3;

    // Result kinds
    localparam logic KIND_TX  = 1'b0;
    localparam logic KIND_ERR = 1'b1;

    // Command characters
    localparam logic [7:0] CMD_READ  = 8'h72;
    localparam logic [7:0] CMD_WRITE = 8'h77;
    localparam logic [7:0] CMD_DUMP  = 8'h64;
    localparam logic [7:0] CMD_LOAD  = 8'h6c;

    // Memory write sources
    localparam logic [1:0] MEM_NONE  = 2'd0;
    localparam logic [1:0] MEM_LOAD  = 2'd1;
    localparam logic [1:0] MEM_CMD   = 2'd2;
    localparam logic [1:0] MEM_CLEAR = 2'd3;

    // Read pointer operations
    localparam logic [1:0] PTR_HOLD = 2'd0;
    localparam logic [1:0] PTR_CMD  = 2'd1;
    localparam logic [1:0] PTR_DUMP = 2'd2;
    localparam logic [1:0] PTR_INC  = 2'd3;

    typedef struct packed {
        logic             cap_byte;
        logic [1:0]       cap_idx;
        logic [1:0]       mem_op;
        logic             dump_rst;
        logic             dump_adv;
        logic             load_start;
        logic [1:0]       ptr_op;
        logic             push;
        logic             push_mem;
        logic             push_kind;
        logic [7:0]       push_tx;
        logic [1:0]       push_code;
        logic             push_last;
    } t_dp_cmd;

    typedef struct packed {
        logic             out_free;
        logic             clear_last;
        logic [CNT_W-1:0] chunk_len;
        logic             dump_zero;
        logic             load_done;
        logic [7:0]       cmd0;
    } t_dp_stat;

endpackage

`default_nettype wire

[rtl/smpp_dp.sv]
// Datapath: byte memory, command bytes, address registers and output word register.
`default_nettype none

module smpp_dp import smpp_pkg::*; #(
    parameter int ADDR_BITS   = 15,
    parameter int CHUNK_BYTES = 63
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [7:0] i_rx_byte,
    input  wire t_dp_cmd    i_cmd,
    output t_dp_stat        o_stat,
    input  wire logic       i_out_ready,
    output logic            o_out_valid,
    output logic            o_out_kind,
    output logic [7:0]      o_out_tx,
    output logic [1:0]      o_out_code,
    output logic            o_out_last
);

    localparam int MEM_DEPTH = 1 << ADDR_BITS;

    logic [7:0]           r_mem [MEM_DEPTH];
    logic [7:0]           r_rd_data;
    logic [ADDR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [ADDR_BITS-1:0] r_clr_addr;
    logic [7:0]           r_cmd [4];
    logic [ADDR_BITS-1:0] r_dump_addr;
    logic [15:0]          r_load_addr;
    logic [15:0]          r_load_target;
    logic                 r_out_valid;
    logic                 r_out_kind;
    logic [7:0]           r_out_tx;
    logic [1:0]           r_out_code;
    logic                 r_out_last;

    logic [15:0]          w_cmd_word;
    logic [ADDR_BITS-1:0] w_cmd_addr;
    logic [ADDR_BITS:0]   w_rem;
    logic                 w_out_free;
    logic [ADDR_BITS-1:0] w_wr_addr;
    logic [7:0]           w_wr_data;

    assign w_cmd_word = {r_cmd[1], r_cmd[2]};
    assign w_cmd_addr = w_cmd_word[ADDR_BITS-1:0];
    // bytes left from the dump address to the end of the memory
    assign w_rem      = {1'b1, {ADDR_BITS{1'b0}}} - {1'b0, r_dump_addr};
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_stat.out_free   = w_out_free;
        o_stat.clear_last = &r_clr_addr;
        o_stat.chunk_len  = (w_rem < (ADDR_BITS+1)'(CHUNK_BYTES)) ? w_rem[CNT_W-1:0]
                                                                   : CNT_W'(CHUNK_BYTES);
        o_stat.dump_zero  = (r_dump_addr == '0);
        o_stat.load_done  = (r_load_addr >= r_load_target);
        o_stat.cmd0       = r_cmd[0];
    end

    always_comb begin
        case (i_cmd.ptr_op)
            PTR_CMD:  n_rd_ptr = w_cmd_addr;
            PTR_DUMP: n_rd_ptr = r_dump_addr;
            PTR_INC:  n_rd_ptr = r_rd_ptr + 1'b1;
            default:  n_rd_ptr = r_rd_ptr;
        endcase
    end

    always_comb begin
        case (i_cmd.mem_op)
            MEM_LOAD: begin
                w_wr_addr = r_load_addr[ADDR_BITS-1:0];
                w_wr_data = i_rx_byte;
            end
            MEM_CMD: begin
                w_wr_addr = w_cmd_addr;
                w_wr_data = r_cmd[3];
            end
            default: begin
                w_wr_addr = r_clr_addr;
                w_wr_data = 8'hFF;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_op != MEM_NONE) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        r_rd_data <= r_mem[n_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        r_rd_ptr <= n_rd_ptr;
        if (i_cmd.push) begin
            r_out_kind <= i_cmd.push_kind;
            r_out_tx   <= i_cmd.push_mem ? r_rd_data : i_cmd.push_tx;
            r_out_code <= i_cmd.push_code;
            r_out_last <= i_cmd.push_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr    <= '0;
            r_cmd[0]      <= '0;
            r_cmd[1]      <= '0;
            r_cmd[2]      <= '0;
            r_cmd[3]      <= '0;
            r_dump_addr   <= '0;
            r_load_addr   <= '0;
            r_load_target <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cmd.mem_op == MEM_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.cap_byte) begin
                r_cmd[i_cmd.cap_idx] <= i_rx_byte;
            end
            if (i_cmd.dump_rst) begin
                r_dump_addr <= '0;
            end else if (i_cmd.dump_adv) begin
                r_dump_addr <= r_dump_addr + ADDR_BITS'(o_stat.chunk_len);
            end
            if (i_cmd.load_start) begin
                r_load_target <= w_cmd_word;
                r_load_addr   <= '0;
            end else if (i_cmd.mem_op == MEM_LOAD && r_load_addr != 16'hFFFF) begin
                // saturate the byte count at its top value
                r_load_addr <= r_load_addr + 16'd1;
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_kind  = r_out_kind;
    assign o_out_tx    = r_out_tx;
    assign o_out_code  = r_out_code;
    assign o_out_last  = r_out_last;

endmodule

`default_nettype wire

[rtl/smpp_ctrl.sv]
// Controller: packet framing, protocol phase and reply sequencing state machine.
`default_nettype none

module smpp_ctrl import smpp_pkg::*; #(
    parameter int CHUNK_BYTES = 63
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_rx_valid,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_rx_ready,
    input  wire t_dp_stat   i_stat,
    output t_dp_cmd         o_cmd
);

    localparam logic [7:0] CMD_CAP = 8'(CHUNK_BYTES + 1);
    localparam logic [7:0] ACK_CAP = 8'(CHUNK_BYTES);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_RX    = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_ACK   = 3'd3;
    localparam logic [2:0] S_ERR   = 3'd4;
    localparam logic [2:0] S_HDR   = 3'd5;
    localparam logic [2:0] S_DATA  = 3'd6;

    logic [2:0]       r_state,    n_state;
    logic [2:0]       r_phase,    n_phase;
    logic [7:0]       r_pkt_len,  n_pkt_len;
    logic [6:0]       r_seen,     n_seen;
    logic [CNT_W-1:0] r_count,    n_count;
    logic             r_src_dump, n_src_dump;
    logic             r_load_ack, n_load_ack;
    logic [1:0]       r_err,      n_err;

    logic [6:0] w_seen_inc;
    logic [7:0] w_seen8;
    logic       w_full;
    logic       w_over_cmd;
    logic       w_over_ack;

    assign w_seen_inc = r_seen + 7'd1;
    assign w_seen8    = {1'b0, w_seen_inc};
    assign w_full     = (w_seen8 >= r_pkt_len);
    assign w_over_cmd = (r_pkt_len > CMD_CAP) && (w_seen8 >= CMD_CAP);
    assign w_over_ack = (r_pkt_len > ACK_CAP) && (w_seen8 >= ACK_CAP);

    assign o_rx_ready = (r_state == S_RX);

    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_pkt_len  = r_pkt_len;
        n_seen     = r_seen;
        n_count    = r_count;
        n_src_dump = r_src_dump;
        n_load_ack = r_load_ack;
        n_err      = r_err;
        o_cmd      = '0;

        case (r_state)
            S_CLEAR: begin
                o_cmd.mem_op = MEM_CLEAR;
                if (i_stat.clear_last) begin
                    n_state = S_RX;
                end
            end

            S_RX: begin
                if (i_rx_valid) begin
                    // the first four body bytes land in the command register file
                    if (r_phase == PH_CMD || r_phase == PH_ACK_BODY ||
                        r_phase == PH_LOAD_BODY) begin
                        o_cmd.cap_byte = (r_seen < 7'd4);
                        o_cmd.cap_idx  = r_seen[1:0];
                        n_seen         = w_seen_inc;
                    end
                    case (r_phase)
                        PH_IDLE: begin
                            if (i_rx_byte != 8'd0) begin
                                n_pkt_len = i_rx_byte;
                                n_seen    = '0;
                                n_phase   = PH_CMD;
                            end
                        end
                        PH_CMD: begin
                            if (w_over_cmd) begin
                                n_err   = ERR_CORRUPT;
                                n_phase = PH_IDLE;
                                n_state = S_ERR;
                            end else if (w_full) begin
                                n_phase = PH_IDLE;
                                n_state = S_EXEC;
                            end
                        end
                        PH_ACK_LEN: begin
                            if (i_rx_byte != 8'd0) begin
                                n_pkt_len = i_rx_byte;
                                n_seen    = '0;
                                n_phase   = PH_ACK_BODY;
                            end else if (i_stat.dump_zero) begin
                                n_phase = PH_IDLE;
                            end else begin
                                n_count    = i_stat.chunk_len;
                                n_src_dump = 1'b1;
                                n_state    = S_HDR;
                            end
                        end
                        PH_ACK_BODY: begin
                            if (w_over_ack) begin
                                n_err   = ERR_CORRUPT;
                                n_phase = PH_IDLE;
                                n_state = S_ERR;
                            end else if (w_full) begin
                                // a one-byte 'r' reply asks for a reset
                                if (r_pkt_len == 8'd1 && i_rx_byte == CMD_READ) begin
                                    n_err = ERR_RESET;
                                end else begin
                                    n_err = ERR_UNEXPECTED;
                                end
                                n_phase = PH_IDLE;
                                n_state = S_ERR;
                            end
                        end
                        PH_LOAD_LEN: begin
                            if (i_rx_byte != 8'd0) begin
                                n_pkt_len = i_rx_byte;
                                n_seen    = '0;
                                n_phase   = PH_LOAD_BODY;
                            end else begin
                                n_load_ack = 1'b1;
                                n_state    = S_ACK;
                            end
                        end
                        PH_LOAD_BODY: begin
                            if (r_pkt_len <= CMD_CAP) begin
                                o_cmd.mem_op = MEM_LOAD;
                            end
                            if (w_over_cmd) begin
                                n_err   = ERR_CORRUPT;
                                n_phase = PH_IDLE;
                                n_state = S_ERR;
                            end else if (w_full) begin
                                n_load_ack = 1'b1;
                                n_state    = S_ACK;
                            end
                        end
                        default: begin
                            n_phase = PH_IDLE;
                        end
                    endcase
                end
            end

            S_EXEC: begin
                if (i_stat.cmd0 == CMD_READ && r_pkt_len == 8'd3) begin
                    n_count    = CNT_W'(1);
                    n_src_dump = 1'b0;
                    n_state    = S_HDR;
                end else if (i_stat.cmd0 == CMD_WRITE && r_pkt_len == 8'd4) begin
                    o_cmd.mem_op = MEM_CMD;
                    n_load_ack   = 1'b0;
                    n_state      = S_ACK;
                end else if (i_stat.cmd0 == CMD_DUMP && r_pkt_len == 8'd1) begin
                    o_cmd.dump_rst = 1'b1;
                    n_count        = CNT_W'(CHUNK_BYTES);
                    n_src_dump     = 1'b1;
                    n_phase        = PH_ACK_LEN;
                    n_state        = S_HDR;
                end else if (i_stat.cmd0 == CMD_LOAD && r_pkt_len == 8'd3) begin
                    o_cmd.load_start = 1'b1;
                    n_load_ack       = 1'b1;
                    n_state          = S_ACK;
                end else if (i_stat.cmd0 == CMD_READ && r_pkt_len == 8'd1) begin
                    n_state = S_RX;
                end else begin
                    n_err   = ERR_UNKNOWN;
                    n_state = S_ERR;
                end
            end

            S_ACK: begin
                if (i_stat.out_free) begin
                    o_cmd.push      = 1'b1;
                    o_cmd.push_kind = KIND_TX;
                    o_cmd.push_last = 1'b1;
                    if (r_load_ack) begin
                        n_phase = i_stat.load_done ? PH_IDLE : PH_LOAD_LEN;
                    end
                    n_state = S_RX;
                end
            end

            S_ERR: begin
                if (i_stat.out_free) begin
                    o_cmd.push      = 1'b1;
                    o_cmd.push_kind = KIND_ERR;
                    o_cmd.push_code = r_err;
                    o_cmd.push_last = 1'b1;
                    n_state         = S_RX;
                end
            end

            S_HDR: begin
                // keep the read pointer on the first byte while the header waits
                o_cmd.ptr_op = r_src_dump ? PTR_DUMP : PTR_CMD;
                if (i_stat.out_free) begin
                    o_cmd.push      = 1'b1;
                    o_cmd.push_kind = KIND_TX;
                    o_cmd.push_tx   = 8'(r_count);
                    o_cmd.dump_adv  = r_src_dump;
                    n_state         = S_DATA;
                end
            end

            S_DATA: begin
                if (i_stat.out_free) begin
                    o_cmd.push      = 1'b1;
                    o_cmd.push_mem  = 1'b1;
                    o_cmd.push_kind = KIND_TX;
                    o_cmd.push_last = (r_count == CNT_W'(1));
                    o_cmd.ptr_op    = PTR_INC;
                    n_count         = r_count - CNT_W'(1);
                    if (r_count == CNT_W'(1)) begin
                        n_state = S_RX;
                    end
                end else begin
                    o_cmd.ptr_op = PTR_HOLD;
                end
            end

            default: begin
                n_state = S_RX;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_phase    <= PH_IDLE;
            r_pkt_len  <= '0;
            r_seen     <= '0;
            r_count    <= '0;
            r_src_dump <= 1'b0;
            r_load_ack <= 1'b0;
            r_err      <= ERR_RESET;
        end else begin
            r_state    <= n_state;
            r_phase    <= n_phase;
            r_pkt_len  <= n_pkt_len;
            r_seen     <= n_seen;
            r_count    <= n_count;
            r_src_dump <= n_src_dump;
            r_load_ack <= n_load_ack;
            r_err      <= n_err;
        end
    end

endmodule

`default_nettype wire

[rtl/serial_memory_programmer_protocol_unit.sv]
// Top level of the serial memory programmer protocol unit.
`default_nettype none

// Takes received serial bytes on the slave stream, frames them into length-prefixed
// packets and runs the read / write / dump / load programmer protocol on an internal
// byte memory of 2**ADDR_BITS entries; replies and error reports leave on the master
// stream, one word per result, tlast on the final result caused by an input byte.
// After reset the memory is swept to 0xFF, one entry a cycle, over all 2**ADDR_BITS
// entries (32768 at the default), and no input word is taken during that pass. The
// controller pushes replies one word a cycle through the output register while the
// master side takes them, with the registered memory read feeding the data words; no
// new input byte is taken until the results of the last one have been pushed. A
// stalled master side holds the unit in place.
module serial_memory_programmer_protocol_unit import smpp_pkg::*; #(
    parameter int ADDR_BITS   = 15,
    parameter int CHUNK_BYTES = 63
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [7:0] tx_byte, [9:8] error_code
    output logic             m_axis_tuser,   // [0] result_kind
    output logic             m_axis_tlast
);

    t_dp_cmd    w_cmd;
    t_dp_stat   w_stat;
    logic [7:0] w_tx;
    logic [1:0] w_code;

    smpp_ctrl #(
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (s_axis_tvalid),
        .i_rx_byte  (s_axis_tdata),
        .o_rx_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    smpp_dp #(
        .ADDR_BITS   (ADDR_BITS),
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx_byte   (s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_kind  (m_axis_tuser),
        .o_out_tx    (w_tx),
        .o_out_code  (w_code),
        .o_out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, w_code, w_tx};

endmodule

`default_nettype wire
